// ===== rtl/trickle_timer_assert.svh =====
// ============================================================================
// Trickle timer assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ============================================================================
`ifndef TRICKLE_TIMER_ASSERT_SVH
`define TRICKLE_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trickle timer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trickle timer check failed");

`endif

// ===== rtl/tt_pkg.sv =====
// ============================================================================
// Trickle timer package
// Event codes, register indexes and the request and result payload types.
// ============================================================================
package tt_pkg;

  // Event codes carried in the cmd field.
  localparam logic [2:0] CMD_TICK         = 3'd0;
  localparam logic [2:0] CMD_START        = 3'd1;
  localparam logic [2:0] CMD_STOP         = 3'd2;
  localparam logic [2:0] CMD_CONSISTENT   = 3'd3;
  localparam logic [2:0] CMD_INCONSISTENT = 3'd4;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_IMIN = 2'd0;
  localparam logic [1:0] REG_IMAX = 2'd1;
  localparam logic [1:0] REG_K    = 2'd2;

  localparam logic [31:0] IMIN_RESET = 32'd100;
  localparam logic [31:0] IMAX_RESET = 32'd102400;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] rand_interval;
    logic [31:0] rand_transmit;
  } event_t;

  typedef struct packed {
    logic        transmit_fire;
    logic        interval_done;
    logic        running;
    logic [31:0] interval_now_ms;
    logic [7:0]  heard_count;
  } report_t;

endpackage

// ===== rtl/tt_chan_if.sv =====
// ============================================================================
// Trickle timer channel
// Valid/ready channel that carries one request payload of a chosen type.
// ============================================================================
interface tt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/trickle_timer.sv =====
// ============================================================================
// Trickle timer
// RFC 6206 style trickle timer advanced by one event request per clock.
// ============================================================================
// The block takes one event request per clock (a millisecond tick, start,
// stop, consistent heard or inconsistent heard) and returns exactly one
// status request for each, carrying the transmit decision, the end of an
// interval, the running flag, the current interval length and the heard
// counter after the event. Every event is finished in the cycle it is
// accepted: the timer state updates at that edge and the status lands in a
// single result register, and the sustained rate is one event per clock
// while the status side keeps taking results. A new event is accepted
// whenever the result register is empty or is being drained in the same
// cycle; a stalled status side holds the event side. The transmit time
// inside an interval is not stored as a number: the random word drawn at
// the start of the interval is kept, and the time is rebuilt from it and
// the current interval length by one multiplier on every tick. Start draws
// the interval length with a second, parallel multiplier. The user must
// write configuration through the APB port only while no event is in flight;
// the block does not enforce this. Registers: bytes 0 (Imin), 4 (Imax), 8 (k).
// ============================================================================
`include "trickle_timer_assert.svh"

module trickle_timer #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tt_chan_if.sink     events,
  tt_chan_if.source   reports
);

  localparam int SPAN_W = TIME_WIDTH + 1;
  localparam int SPAN_X = (SPAN_W > 33) ? SPAN_W : 33;
  localparam int TW_X   = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int CW_X   = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  // Returns lo + floor(span * r / 2^32), kept to TIME_WIDTH bits. The span is
  // split at bit 32 so that each partial product stays within 32 by 32 bits.
  function automatic logic [TIME_WIDTH-1:0] pick(
    input logic [TIME_WIDTH-1:0] lo,
    input logic [SPAN_W-1:0]     span,
    input logic [31:0]           r
  );
    logic [SPAN_X-1:0] span_x;
    logic [63:0]       p_lo;
    logic [SPAN_X-1:0] p_hi;
    logic [SPAN_X-1:0] off;
    span_x = SPAN_X'(span);
    p_lo   = span_x[31:0] * r;
    p_hi   = span_x[SPAN_X-1:32] * r;
    off    = p_hi + SPAN_X'(p_lo[63:32]);
    return TIME_WIDTH'(SPAN_X'(lo) + off);
  endfunction

  // Configuration registers.
  logic [TIME_WIDTH-1:0] imin;
  logic [TIME_WIDTH-1:0] imax;
  logic [7:0]            k;
  logic [TIME_WIDTH-1:0] imax_eff;
  logic [TW_X-1:0]       imin_x;
  logic [TW_X-1:0]       imax_x;

  // Timer state.
  logic                   active;
  logic [TIME_WIDTH-1:0]  interval_len;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   pending;
  logic [COUNT_WIDTH-1:0] count;
  logic [31:0]            tx_rand;

  logic                   active_next;
  logic [TIME_WIDTH-1:0]  interval_len_next;
  logic [TIME_WIDTH-1:0]  elapsed_next;
  logic                   pending_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [31:0]            tx_rand_next;

  // Result register.
  logic             res_valid;
  tt_pkg::report_t  res_data;
  tt_pkg::report_t  res_data_next;

  // Datapath signals.
  logic                  accept;
  logic [TIME_WIDTH-1:0] half;
  logic [TIME_WIDTH-1:0] transmit_at;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [TIME_WIDTH-1:0] start_len;
  logic [SPAN_W-1:0]     start_span;
  logic [SPAN_W-1:0]     len_dbl;
  logic [TIME_WIDTH-1:0] len_capped;
  logic [CW_X-1:0]       count_x;
  logic [CW_X-1:0]       k_x;
  logic                  may_fire;
  logic                  fire;
  logic                  done;
  logic [TW_X-1:0]       len_out_x;
  logic [CW_X-1:0]       count_out_x;

  // --------------------------------------------------------------------------
  // APB configuration port. Writes complete in the access phase; pready is
  // tied high so there are no wait states.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign imin_x = TW_X'(imin);
  assign imax_x = TW_X'(imax);

  always_comb begin
    case (paddr[3:2])
      tt_pkg::REG_IMIN: prdata = imin_x[31:0];
      tt_pkg::REG_IMAX: prdata = imax_x[31:0];
      tt_pkg::REG_K:    prdata = {24'd0, k};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imin <= TIME_WIDTH'(tt_pkg::IMIN_RESET);
      imax <= TIME_WIDTH'(tt_pkg::IMAX_RESET);
      k    <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        tt_pkg::REG_IMIN: imin <= TIME_WIDTH'(pwdata);
        tt_pkg::REG_IMAX: imax <= TIME_WIDTH'(pwdata);
        tt_pkg::REG_K:    k <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // An Imax below Imin is treated as Imin, both on start and for the cap.
  assign imax_eff = (imax < imin) ? imin : imax;

  // --------------------------------------------------------------------------
  // Event datapath.
  // --------------------------------------------------------------------------
  assign accept        = events.valid && events.ready;
  assign events.ready  = !res_valid || reports.ready;
  assign reports.valid = res_valid;
  assign reports.data  = res_data;

  // The transmit time of the running interval lies in [I/2, I) and is
  // rebuilt from the stored random word each cycle.
  assign half        = interval_len >> 1;
  assign transmit_at = pick(half, SPAN_W'(interval_len - half), tx_rand);

  // Elapsed time saturates at the all-ones value.
  assign elapsed_inc = (elapsed != '1) ? elapsed + TIME_WIDTH'(1) : elapsed;

  // Start draws I from the closed range [Imin, Imax].
  assign start_span = SPAN_W'(imax_eff) - SPAN_W'(imin) + SPAN_W'(1);
  assign start_len  = pick(imin, start_span, events.data.rand_interval);

  // Doubling is done one bit wider so it cannot wrap before the cap.
  assign len_dbl    = {interval_len, 1'b0};
  assign len_capped = (len_dbl < SPAN_W'(imax_eff)) ? len_dbl[TIME_WIDTH-1:0] : imax_eff;

  // A k of zero means the node always transmits.
  assign count_x  = CW_X'(count);
  assign k_x      = CW_X'(k);
  assign may_fire = (k == 8'd0) || (count_x < k_x);

  always_comb begin
    active_next       = active;
    interval_len_next = interval_len;
    elapsed_next      = elapsed;
    pending_next      = pending;
    count_next        = count;
    tx_rand_next      = tx_rand;
    fire              = 1'b0;
    done              = 1'b0;

    case (events.data.cmd)
      tt_pkg::CMD_TICK: begin
        if (active) begin
          elapsed_next = elapsed_inc;
          if (pending && (elapsed_inc >= transmit_at)) begin
            pending_next = 1'b0;
            fire         = may_fire;
          end
          if (elapsed_inc >= interval_len) begin
            interval_len_next = len_capped;
            done              = 1'b1;
            count_next        = '0;
            pending_next      = 1'b1;
            elapsed_next      = '0;
            active_next       = 1'b1;
            tx_rand_next      = events.data.rand_transmit;
          end
        end
      end
      tt_pkg::CMD_START: begin
        interval_len_next = start_len;
        count_next        = '0;
        pending_next      = 1'b1;
        elapsed_next      = '0;
        active_next       = 1'b1;
        tx_rand_next      = events.data.rand_transmit;
      end
      tt_pkg::CMD_STOP: begin
        active_next  = 1'b0;
        pending_next = 1'b0;
      end
      tt_pkg::CMD_CONSISTENT: begin
        if (count != '1) begin
          count_next = count + COUNT_WIDTH'(1);
        end
      end
      tt_pkg::CMD_INCONSISTENT: begin
        // Falling back to Imin also restarts a stopped timer.
        if (interval_len > imin) begin
          interval_len_next = imin;
          count_next        = '0;
          pending_next      = 1'b1;
          elapsed_next      = '0;
          active_next       = 1'b1;
          tx_rand_next      = events.data.rand_transmit;
        end
      end
      default: ;
    endcase
  end

  assign len_out_x   = TW_X'(interval_len_next);
  assign count_out_x = CW_X'(count_next);

  always_comb begin
    res_data_next.transmit_fire   = fire;
    res_data_next.interval_done   = done;
    res_data_next.running         = active_next;
    res_data_next.interval_now_ms = len_out_x[31:0];
    res_data_next.heard_count     = count_out_x[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      interval_len <= '0;
      elapsed      <= '0;
      pending      <= 1'b0;
      count        <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        active       <= active_next;
        interval_len <= interval_len_next;
        elapsed      <= elapsed_next;
        pending      <= pending_next;
        count        <= count_next;
        res_valid    <= 1'b1;
      end else if (reports.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_rand  <= tx_rand_next;
      res_data <= res_data_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A waiting result that is not taken must hold off the event side.
  `TT_ASSERT_SAME(a_hold_on_stall, res_valid && !reports.ready, !events.ready)
  // Every accepted event leaves a result behind.
  `TT_ASSERT_NEXT(a_result_follows, accept, res_valid)
  // A pending transmit only exists while the timer runs.
  `TT_ASSERT_SAME(a_pending_needs_active, pending, active)
  // A new interval always leaves the timer running.
  `TT_ASSERT_SAME(a_done_running, res_valid && res_data.interval_done, res_data.running)

endmodule

// ===== test/trickle_timer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trickle timer testbench
// Drives event requests and register writes into trickle_timer, predicts
// every status request, and compares each one field by field as it arrives.
// ----------------------------------------------------------------------------

module trickle_timer_test;

  // The cmd field has three codes with no meaning; the block must ignore them.
  localparam logic [2:0] CMD_RESERVED_A = 3'd5;
  localparam logic [2:0] CMD_RESERVED_B = 3'd6;
  localparam logic [2:0] CMD_RESERVED_C = 3'd7;

  // Cycles with no request moving on either channel before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Length of the long status-side hold-off that backs the block up.
  localparam int unsigned HOLD_OFF_LEN = 40;

  // --------------------------------------------------------------------------
  // Trickle timer tracker: keeps its own copy of the timer state and the
  // configuration, works out the status request that each accepted event
  // request must produce, and checks the status requests in order.
  // --------------------------------------------------------------------------
  class trickle_tracker;
    logic [31:0]       imin;
    logic [31:0]       imax;
    logic [7:0]        k;
    bit                active;
    bit                pending;
    logic [31:0]       len;
    logic [31:0]       elapsed;
    logic [31:0]       tx_at;
    logic [7:0]        heard;
    tt_pkg::report_t   expected_reports[$];
    int unsigned       errors;
    int unsigned       fires;
    int unsigned       rollovers;
    int unsigned       events_seen;

    function new();
      imin        = tt_pkg::IMIN_RESET;
      imax        = tt_pkg::IMAX_RESET;
      k           = '0;
      active      = 1'b0;
      pending     = 1'b0;
      len         = '0;
      elapsed     = '0;
      tx_at       = '0;
      heard       = '0;
      errors      = 0;
      fires       = 0;
      rollovers   = 0;
      events_seen = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        tt_pkg::REG_IMIN: imin = value;
        tt_pkg::REG_IMAX: imax = value;
        tt_pkg::REG_K:    k = value[7:0];
        default: ;
      endcase
    endfunction

    // lo + floor(span * r / 2^32); span never exceeds 2^32 here.
    function logic [31:0] scaled_pick(logic [31:0] lo, logic [63:0] span, logic [31:0] r);
      logic [63:0] prod;
      prod = span * {32'b0, r};
      return lo + prod[63:32];
    endfunction

    // A maximum below the minimum is treated as the minimum.
    function logic [31:0] cap_len();
      return (imax < imin) ? imin : imax;
    endfunction

    function void open_interval(logic [31:0] r);
      logic [31:0] half;
      half    = len >> 1;
      heard   = '0;
      tx_at   = scaled_pick(half, {32'b0, len - half}, r);
      pending = 1'b1;
      elapsed = '0;
      active  = 1'b1;
    endfunction

    function void note_event(tt_pkg::event_t ev);
      tt_pkg::report_t rep;
      logic [63:0]     dbl;
      logic [31:0]     top;
      rep = '0;
      case (ev.cmd)
        tt_pkg::CMD_TICK: if (active) begin
          if (elapsed != '1) elapsed++;
          if (pending && elapsed >= tx_at) begin
            pending = 1'b0;
            rep.transmit_fire = (k == 0) || (heard < k);
          end
          if (elapsed >= len) begin
            // Doubling is done one bit wider so that it cannot wrap.
            dbl = {31'b0, len, 1'b0};
            top = cap_len();
            len = (dbl < {32'b0, top}) ? dbl[31:0] : top;
            open_interval(ev.rand_transmit);
            rep.interval_done = 1'b1;
          end
        end
        tt_pkg::CMD_START: begin
          top = cap_len();
          len = scaled_pick(imin, {32'b0, top} - {32'b0, imin} + 64'd1, ev.rand_interval);
          open_interval(ev.rand_transmit);
        end
        tt_pkg::CMD_STOP: begin
          active  = 1'b0;
          pending = 1'b0;
        end
        tt_pkg::CMD_CONSISTENT: if (heard != '1) heard++;
        tt_pkg::CMD_INCONSISTENT: if (len > imin) begin
          // This also wakes a stopped timer.
          len = imin;
          open_interval(ev.rand_transmit);
        end
        default: ;
      endcase
      rep.running         = active;
      rep.interval_now_ms = len;
      rep.heard_count     = heard;
      if (rep.transmit_fire) fires++;
      if (rep.interval_done) rollovers++;
      events_seen++;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(tt_pkg::report_t got);
      tt_pkg::report_t want;
      if (expected_reports.size() == 0) begin
        $error("status request arrived with no event request outstanding");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.transmit_fire !== want.transmit_fire) begin
        $error("transmit_fire: expected %0d, got %0d", want.transmit_fire, got.transmit_fire);
        errors++;
      end
      if (got.interval_done !== want.interval_done) begin
        $error("interval_done: expected %0d, got %0d", want.interval_done, got.interval_done);
        errors++;
      end
      if (got.running !== want.running) begin
        $error("running: expected %0d, got %0d", want.running, got.running);
        errors++;
      end
      if (got.interval_now_ms !== want.interval_now_ms) begin
        $error("interval_now_ms: expected %0d, got %0d",
               want.interval_now_ms, got.interval_now_ms);
        errors++;
      end
      if (got.heard_count !== want.heard_count) begin
        $error("heard_count: expected %0d, got %0d", want.heard_count, got.heard_count);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tt_chan_if #(.payload_t(tt_pkg::event_t))  events_ch ();
  tt_chan_if #(.payload_t(tt_pkg::report_t)) reports_ch ();

  trickle_timer dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .events  (events_ch),
    .reports (reports_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  trickle_tracker tracker;

  // Status-side behavior, set by the stimulus and read by the receiver.
  bit          stall_on;
  int unsigned hold_off_cycles;
  int unsigned settings_applied;
  int unsigned quiet_cycles;
  // Set by the receiver once the long hold-off has been served.
  bit          hold_off_done;

  // --------------------------------------------------------------------------
  // Watchdog. Any request moving on either channel counts as progress; a long
  // silence means the block has hung or lost a status request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (events_ch.valid && events_ch.ready) || (reports_ch.valid && reports_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("trickle_timer verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Status receiver. It normally takes every status request, stalls in short
  // random bursts while stall_on is set, and on demand holds off for a long
  // stretch counted here, so that the block fills and pushes back on events.
  // --------------------------------------------------------------------------
  initial begin
    reports_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_off_cycles != 0 && !hold_off_done) begin
        reports_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_done = 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        reports_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        reports_ch.ready <= 1'b1;
        @(posedge clk);
        if (reports_ch.valid) tracker.check_report(reports_ch.data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event driver and register access.
  // --------------------------------------------------------------------------

  // Offers one event request and returns at the edge where it is taken. The
  // valid line is left high so the next request can follow without a gap.
  task automatic send_event(logic [2:0] cmd, logic [31:0] r_int, logic [31:0] r_tx);
    tt_pkg::event_t ev;
    ev.cmd           = cmd;
    ev.rand_interval = r_int;
    ev.rand_transmit = r_tx;
    events_ch.valid <= 1'b1;
    events_ch.data  <= ev;
    do @(posedge clk); while (events_ch.ready !== 1'b1);
    tracker.note_event(ev);
  endtask

  // Random words lean on the two ends now and then, since those pick the
  // bounds of every range.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly ticks so that intervals really run out, with starts, stops and
  // heard transmissions mixed in and a few meaningless codes as noise.
  function automatic logic [2:0] rand_cmd();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 58) return tt_pkg::CMD_TICK;
    else if (w < 66) return tt_pkg::CMD_START;
    else if (w < 71) return tt_pkg::CMD_STOP;
    else if (w < 84) return tt_pkg::CMD_CONSISTENT;
    else if (w < 94) return tt_pkg::CMD_INCONSISTENT;
    else return 3'($urandom_range(CMD_RESERVED_A, CMD_RESERVED_C));
  endfunction

  task automatic run_events(int unsigned count, bit gaps);
    repeat (count) begin
      if (gaps && $urandom_range(0, 4) == 0) begin
        events_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      send_event(rand_cmd(), rand_word(), rand_word());
    end
  endtask

  // Stops offering events and waits until every status request is back, so
  // that the block is idle and safe to reconfigure.
  task automatic settle();
    events_ch.valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
  endtask

  // One APB write followed by a read back of the same register, then an idle
  // bus phase so the next transfer starts from a clean setup phase.
  task automatic program_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] want;
    want = (idx == tt_pkg::REG_K) ? {24'b0, value[7:0]} : value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.set_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("register %0d read back: expected %0h, got %0h", idx, want, prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [31:0] imin, logic [31:0] imax, logic [7:0] k);
    settle();
    program_register(tt_pkg::REG_IMIN, imin);
    program_register(tt_pkg::REG_IMAX, imax);
    program_register(tt_pkg::REG_K, {24'b0, k});
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    stall_on         = 1'b1;
    hold_off_cycles  = 0;
    settings_applied = 0;
    rst             <= 1'b1;
    events_ch.valid <= 1'b0;
    events_ch.data  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk with Imin 2, Imax 8 and k 1. Ticks and heard transmissions
    // arrive first while the timer is stopped, then a start with the smallest
    // random words, a transmission, a rollover, a transmission suppressed by
    // the heard counter, a start with the largest words, and the inconsistent
    // case both as a restart of a stopped timer and as a no-op at Imin.
    apply_settings(32'd2, 32'd8, 8'd1);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_CONSISTENT, '0, '0);
    send_event(tt_pkg::CMD_START, '0, '0);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_CONSISTENT, '0, '0);
    send_event(tt_pkg::CMD_TICK, '0, '1);
    send_event(tt_pkg::CMD_CONSISTENT, '1, '1);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_TICK, '1, '0);
    send_event(tt_pkg::CMD_START, '1, '1);
    send_event(tt_pkg::CMD_STOP, '0, '0);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_INCONSISTENT, '0, '1);
    send_event(tt_pkg::CMD_INCONSISTENT, '1, '0);
    send_event(CMD_RESERVED_A, '1, '1);
    send_event(CMD_RESERVED_B, '0, '0);
    send_event(CMD_RESERVED_C, '1, '0);
    send_event(tt_pkg::CMD_START, 32'h8000_0000, 32'h0000_0001);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_TICK, '0, '0);
    send_event(tt_pkg::CMD_STOP, '0, '0);

    // Zero-length intervals: every tick of a running timer both transmits and rolls over.
    apply_settings(32'd0, 32'd0, 8'd0);
    run_events(12, 1'b1);

    // Short intervals that double up to the cap, first with idling on both
    // sides and then a stretch with none.
    apply_settings(32'd1, 32'd16, 8'd2);
    run_events(12, 1'b1);
    stall_on = 1'b0;
    run_events(12, 1'b0);
    stall_on = 1'b1;

    // Largest k. A stopped timer still counts heard transmissions, so a long
    // run of them drives the counter into saturation before a restart.
    apply_settings(32'd3, 32'd40, 8'd255);
    run_events(5, 1'b1);
    send_event(tt_pkg::CMD_STOP, rand_word(), rand_word());
    repeat (256) send_event(tt_pkg::CMD_CONSISTENT, rand_word(), rand_word());
    send_event(tt_pkg::CMD_START, rand_word(), rand_word());
    run_events(5, 1'b1);

    // Largest Imin with a zero Imax: the maximum falls back to the minimum.
    apply_settings(32'hFFFF_FFFF, 32'd0, 8'd0);
    run_events(8, 1'b1);

    // Full range of interval lengths; an inconsistent request drops to zero.
    apply_settings(32'd0, 32'hFFFF_FFFF, 8'd3);
    run_events(15, 1'b1);

    // A small maximum under the minimum.
    apply_settings(32'd5, 32'd2, 8'd1);
    run_events(12, 1'b1);

    // Back-pressure: the receiver holds off for a long stretch while events
    // keep coming back to back, so the block fills and stalls its input.
    apply_settings(32'd4, 32'd64, 8'd0);
    stall_on = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    run_events(30, 1'b0);

    // Closing stretch with no idling on either side.
    apply_settings(32'd2, 32'd32, 8'd1);
    run_events(20, 1'b0);

    settle();
    repeat (5) @(posedge clk);

    $display("Covered %0d event requests under %0d register settings, including a long",
             tracker.events_seen, settings_applied);
    $display("status hold-off; %0d transmissions and %0d rollovers were predicted.",
             tracker.fires, tracker.rollovers);
    if (tracker.errors == 0) begin
      $display("trickle_timer verification clean");
    end else begin
      $display("trickle_timer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tt_pkg.sv
rtl/tt_chan_if.sv
rtl/trickle_timer.sv
test/trickle_timer_test.sv
